// File: design/satl_pkg.sv
// Shared types and constants for the set-associative cache tag lookup.
package satl_pkg;

    // Width of an access-clock stamp.
    localparam int STAMP_W = 32;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Width of the reported way number.
    localparam int OUT_WAY_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY_LRU  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd3;

    // Register reset values.
    localparam logic            RST_POLICY_LRU  = 1'b1;
    localparam logic [3:0]      RST_OFFSET_BITS = 4'd6;
    localparam logic [3:0]      RST_SET_BITS    = 4'd6;
    localparam logic [3:0]      RST_WAYS_IN_USE = 4'd4;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_FILL
    } t_state;

endpackage

// File: design/set_assoc_cache_tag_lookup_core.sv
// Top level of the set-associative cache tag lookup (LRU / FIFO replacement).
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------------
//  access in | start / busy       | i_address, i_is_write
//  result    | o_done (strobe)    | o_hit, o_memory_read, o_memory_write, o_way
//  config    | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// A beat is taken when start is high and busy is low. Hit, miss with a free
// way, or miss with a single way in use: set row read, then row write-back with
// the result. Miss into a full set of several ways: row read, then a stamp search
// that walks one way per cycle, then the fill write. The row memory has a single
// read and a single write port. After reset busy stays high while the row memory
// is cleared one set per cycle; config writes are taken throughout.
// Results are strobed for one cycle on o_done; the receiver cannot stall.
module set_assoc_cache_tag_lookup_core #(
    parameter int MAX_SETS      = 1024,
    parameter int MAX_WAYS      = 8,
    parameter int ADDRESS_WIDTH = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // access beat
    input  logic                              start,
    output logic                              busy,
    input  logic [ADDRESS_WIDTH-1:0]          i_address,
    input  logic                              i_is_write,
    // result beat
    output logic                              o_done,
    output logic                              o_hit,
    output logic                              o_memory_read,
    output logic                              o_memory_write,
    output logic [satl_pkg::OUT_WAY_W-1:0]    o_way,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [satl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [satl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int STAMP_W = satl_pkg::STAMP_W;
    localparam int TAG_W   = ADDRESS_WIDTH;
    localparam int ENT_W   = 1 + TAG_W + STAMP_W;        // {valid, tag, stamp}
    localparam int ROW_W   = MAX_WAYS * ENT_W;
    localparam int SET_AW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int MSB     = $clog2(MAX_SETS + 1) - 1;   // floor(log2(MAX_SETS))
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W   = $clog2(MAX_WAYS + 1);

    // ---------------- configuration registers ----------------
    logic       r_policy_lru;
    logic [3:0] r_offset_bits;
    logic [3:0] r_set_bits;
    logic [3:0] r_ways_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy_lru  <= satl_pkg::RST_POLICY_LRU;
            r_offset_bits <= satl_pkg::RST_OFFSET_BITS;
            r_set_bits    <= satl_pkg::RST_SET_BITS;
            r_ways_in_use <= satl_pkg::RST_WAYS_IN_USE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                satl_pkg::CFG_POLICY_LRU:  r_policy_lru  <= i_cfg_data[0];
                satl_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[3:0];
                satl_pkg::CFG_SET_BITS:    r_set_bits    <= i_cfg_data[3:0];
                satl_pkg::CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ---------------- effective geometry ----------------
    logic [4:0]       sb_eff;     // set bits, clamped to what MAX_SETS holds
    logic [4:0]       tag_sh;     // offset + set bits
    logic [5:0]       ways_raw;
    logic [CNT_W-1:0] ways_eff;   // 1 .. MAX_WAYS
    logic [SET_AW-1:0] set_mask;
    logic [ADDRESS_WIDTH-1:0] addr_sh;
    logic [SET_AW-1:0] set_idx;
    logic [TAG_W-1:0]  tag_in;

    always_comb begin
        if ({1'b0, r_set_bits} > 5'(MSB)) begin
            sb_eff = 5'(MSB);
        end else begin
            sb_eff = {1'b0, r_set_bits};
        end
        tag_sh = {1'b0, r_offset_bits} + sb_eff;

        ways_raw = {2'b00, r_ways_in_use};
        if (ways_raw == 6'd0) begin
            ways_raw = 6'd1;
        end else if (ways_raw > 6'(MAX_WAYS)) begin
            ways_raw = 6'(MAX_WAYS);
        end
        ways_eff = CNT_W'(ways_raw);

        for (int i = 0; i < SET_AW; i++) begin
            set_mask[i] = (5'(i) < sb_eff);
        end
    end

    assign addr_sh = i_address >> r_offset_bits;
    assign set_idx = addr_sh[SET_AW-1:0] & set_mask;
    assign tag_in  = TAG_W'(i_address >> tag_sh);

    // ---------------- control registers ----------------
    satl_pkg::t_state r_state, n_state;
    logic [SET_AW-1:0]  r_clr, n_clr;
    logic [STAMP_W-1:0] r_clock, n_clock;
    logic [SET_AW-1:0]  r_set, n_set;
    logic [TAG_W-1:0]   r_tag, n_tag;
    logic               r_wr, n_wr;
    logic [CNT_W-1:0]   r_scan, n_scan;
    logic [STAMP_W-1:0] r_best, n_best;
    logic [WAY_W-1:0]   r_victim, n_victim;

    logic                         r_done, n_done;
    logic                         r_hit, n_hit;
    logic                         r_wr_out, n_wr_out;
    logic [satl_pkg::OUT_WAY_W-1:0] r_way, n_way;

    // ---------------- row memory and match ----------------
    logic                          accept;
    logic                          ram_we;
    logic [SET_AW-1:0]             ram_waddr;
    logic [MAX_WAYS-1:0][ENT_W-1:0] ram_wdata;
    logic [MAX_WAYS-1:0][ENT_W-1:0] row;

    logic [MAX_WAYS-1:0] match;
    logic                m_hit;
    logic [WAY_W-1:0]    m_hit_way;
    logic                m_any_inv;
    logic [WAY_W-1:0]    m_inv_way;

    assign busy   = (r_state != satl_pkg::ST_IDLE);
    assign accept = start && !busy;

    satl_row_ram #(
        .DEPTH (MAX_SETS),
        .WIDTH (ROW_W),
        .AW    (SET_AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_re    (accept),
        .i_raddr (set_idx),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .o_rdata (row)
    );

    satl_way_match #(
        .MAX_WAYS (MAX_WAYS),
        .TAG_W    (TAG_W),
        .ENT_W    (ENT_W),
        .WAY_W    (WAY_W),
        .CNT_W    (CNT_W)
    ) u_match (
        .i_row     (row),
        .i_tag     (r_tag),
        .i_ways    (ways_eff),
        .o_match   (match),
        .o_hit     (m_hit),
        .o_hit_way (m_hit_way),
        .o_any_inv (m_any_inv),
        .o_inv_way (m_inv_way)
    );

    logic [ENT_W-1:0]   fill_ent;
    logic [STAMP_W-1:0] scan_stamp;

    assign fill_ent   = {1'b1, r_tag, r_clock};
    assign scan_stamp = row[r_scan[WAY_W-1:0]][STAMP_W-1:0];

    // ---------------- next state ----------------
    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_clock  = r_clock;
        n_set    = r_set;
        n_tag    = r_tag;
        n_wr     = r_wr;
        n_scan   = r_scan;
        n_best   = r_best;
        n_victim = r_victim;
        n_done   = 1'b0;
        n_hit    = r_hit;
        n_wr_out = r_wr_out;
        n_way    = r_way;

        ram_we    = 1'b0;
        ram_waddr = r_set;
        ram_wdata = row;

        case (r_state)
            satl_pkg::ST_CLEAR: begin
                // one set row zeroed per cycle
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == SET_AW'(MAX_SETS - 1)) begin
                    n_state = satl_pkg::ST_IDLE;
                end
            end

            satl_pkg::ST_IDLE: begin
                if (start) begin
                    n_clock = r_clock + 1'b1;
                    n_set   = set_idx;
                    n_tag   = tag_in;
                    n_wr    = i_is_write;
                    n_state = satl_pkg::ST_LOOKUP;
                end
            end

            satl_pkg::ST_LOOKUP: begin
                if (m_hit) begin
                    // LRU refreshes every matching way
                    for (int w = 0; w < MAX_WAYS; w++) begin
                        if (match[w] && r_policy_lru) begin
                            ram_wdata[w][STAMP_W-1:0] = r_clock;
                        end
                    end
                    ram_we   = 1'b1;
                    n_done   = 1'b1;
                    n_hit    = 1'b1;
                    n_wr_out = r_wr;
                    n_way    = satl_pkg::OUT_WAY_W'(m_hit_way);
                    n_state  = satl_pkg::ST_IDLE;
                end else if (m_any_inv || ways_eff == CNT_W'(1)) begin
                    // free way, or a single way to replace
                    if (m_any_inv) begin
                        ram_wdata[m_inv_way] = fill_ent;
                        n_way = satl_pkg::OUT_WAY_W'(m_inv_way);
                    end else begin
                        ram_wdata[0] = fill_ent;
                        n_way = '0;
                    end
                    ram_we   = 1'b1;
                    n_done   = 1'b1;
                    n_hit    = 1'b0;
                    n_wr_out = r_wr;
                    n_state  = satl_pkg::ST_IDLE;
                end else begin
                    // full set: walk stamps for the oldest
                    n_best   = row[0][STAMP_W-1:0];
                    n_victim = '0;
                    n_scan   = CNT_W'(1);
                    n_state  = satl_pkg::ST_SCAN;
                end
            end

            satl_pkg::ST_SCAN: begin
                if (scan_stamp < r_best) begin
                    n_best   = scan_stamp;
                    n_victim = r_scan[WAY_W-1:0];
                end
                n_scan = r_scan + 1'b1;
                if (n_scan == ways_eff) begin
                    n_state = satl_pkg::ST_FILL;
                end
            end

            satl_pkg::ST_FILL: begin
                ram_wdata[r_victim] = fill_ent;
                ram_we   = 1'b1;
                n_done   = 1'b1;
                n_hit    = 1'b0;
                n_wr_out = r_wr;
                n_way    = satl_pkg::OUT_WAY_W'(r_victim);
                n_state  = satl_pkg::ST_IDLE;
            end

            default: begin
                n_state = satl_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= satl_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_clock <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_clock <= n_clock;
            r_done  <= n_done;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_set    <= n_set;
        r_tag    <= n_tag;
        r_wr     <= n_wr;
        r_scan   <= n_scan;
        r_best   <= n_best;
        r_victim <= n_victim;
        r_hit    <= n_hit;
        r_wr_out <= n_wr_out;
        r_way    <= n_way;
    end

    assign o_done         = r_done;
    assign o_hit          = r_hit;
    assign o_memory_read  = !r_hit;
    assign o_memory_write = r_wr_out;
    assign o_way          = r_way;

endmodule

// File: design/satl_row_ram.sv
// Single-port-write, single-port-read set row memory with registered read data.
module satl_row_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 648,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/satl_way_match.sv
// Per-way tag compare and first-hit / first-invalid priority pick over one set row.
module satl_way_match #(
    parameter int MAX_WAYS = 8,
    parameter int TAG_W    = 48,
    parameter int ENT_W    = 81,
    parameter int WAY_W    = 3,
    parameter int CNT_W    = 4
) (
    input  logic [MAX_WAYS-1:0][ENT_W-1:0] i_row,
    input  logic [TAG_W-1:0]               i_tag,
    input  logic [CNT_W-1:0]               i_ways,
    output logic [MAX_WAYS-1:0]            o_match,
    output logic                           o_hit,
    output logic [WAY_W-1:0]               o_hit_way,
    output logic                           o_any_inv,
    output logic [WAY_W-1:0]               o_inv_way
);

    localparam int STAMP_W = satl_pkg::STAMP_W;

    logic [MAX_WAYS-1:0] inv;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            logic in_use;
            logic vld;
            in_use     = (CNT_W'(w) < i_ways);
            vld        = i_row[w][ENT_W-1];
            o_match[w] = in_use && vld && (i_row[w][STAMP_W +: TAG_W] == i_tag);
            inv[w]     = in_use && !vld;
        end
    end

    // Lowest index wins: scan from the top down.
    always_comb begin
        o_hit_way = '0;
        o_inv_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (o_match[w]) begin
                o_hit_way = WAY_W'(w);
            end
            if (inv[w]) begin
                o_inv_way = WAY_W'(w);
            end
        end
    end

    assign o_hit     = |o_match;
    assign o_any_inv = |inv;

endmodule
